// File: rtl/rcss_pkg.sv
// ----------------------------------------------------------------------------
// rcss_pkg
// Shared constants, types and rounding helpers for the RC setpoint shaper.
// ----------------------------------------------------------------------------
package rcss_pkg;

  // Control tick rate and link-loss timeout, in ticks
  localparam int TICK_RATE_HZ = 200;
  localparam int COUNT_W      = 10;
  localparam logic [COUNT_W-1:0] TIMEOUT_TICKS = COUNT_W'(300);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

  // Field widths
  localparam int CH_W   = 16;
  localparam int REF_W  = 17;
  localparam int YAW_W  = 32;
  localparam int GAIN_W = 16;
  localparam int PROD_W = 2 * REF_W;

  // Yaw rate deadzone, 0.05 rad/s in Q4.12
  localparam logic signed [REF_W-1:0] DEADZONE_POS = REF_W'(205);
  localparam logic signed [REF_W-1:0] DEADZONE_NEG = -DEADZONE_POS;

  // Trapezoid step: q = floor((|sum| + TICK_RATE_HZ) / (2 * TICK_RATE_HZ)),
  // done as a multiply by a rounded-up reciprocal of the divisor.
  localparam int YAW_DIV     = 2 * TICK_RATE_HZ;
  localparam int YAW_SUM_W   = REF_W + 1;
  localparam int YAW_X_W     = YAW_SUM_W + 1;
  localparam int YAW_SHIFT   = 32;
  localparam logic [63:0] YAW_RECIP64 = ((64'd1 << YAW_SHIFT) + 64'(YAW_DIV) - 64'd1)
                                        / 64'(YAW_DIV);
  localparam int YAW_RECIP_W = $clog2(YAW_RECIP64 + 64'd1);
  localparam int YAW_MUL_W   = YAW_X_W + YAW_RECIP_W;
  localparam int YAW_Q_W     = YAW_MUL_W - YAW_SHIFT;
  localparam int YAW_INC_W   = YAW_Q_W + 1;

  // Flight modes
  localparam logic [1:0] MODE_STAB = 2'd1;
  localparam logic [1:0] MODE_ACRO = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIGHT_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBUG_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_GAIN_STAB  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN_STAB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_GAIN_ACRO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN_ACRO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_RATE_GAIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_LIMITS = 3'd7;

  // Products stage: one request with its scaled channels
  typedef struct packed {
    logic                     valid;
    logic                     frame;
    logic                     hold;
    logic                     angle_en;
    logic signed [PROD_W-1:0] roll_prod;
    logic signed [PROD_W-1:0] pitch_prod;
    logic signed [PROD_W-1:0] yaw_prod;
    logic signed [PROD_W-1:0] thr_prod;
    logic signed [CH_W-1:0]   kill;
    logic signed [CH_W-1:0]   aux;
  } s1_t;

  // Divide by 2^14 rounding half up, add an offset, saturate to 17 bits
  function automatic logic signed [REF_W-1:0] round_sat17(
    input logic signed [PROD_W-1:0] p,
    input logic signed [REF_W:0]    offs
  );
    logic signed [PROD_W:0]    t;
    logic signed [PROD_W-14:0] q;
    logic signed [PROD_W-13:0] s;
    logic signed [REF_W-1:0]   r;
    t = {p[PROD_W-1], p} + (PROD_W+1)'(8192);
    q = t[PROD_W:14];
    s = {q[PROD_W-14], q} + (PROD_W-12)'(offs);
    if (s > (PROD_W-12)'(65535)) begin
      r = REF_W'(65535);
    end else if (s < -(PROD_W-12)'(65536)) begin
      r = REF_W'(-65536);
    end else begin
      r = s[REF_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/rc_setpoint_shaper_unit.sv
// ----------------------------------------------------------------------------
// rc_setpoint_shaper_unit
// Turns normalized radio channels into roll, pitch, yaw and throttle setpoints.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_valid / in_ready  | new_frame, hold_timeout, six channels
//   out_    | out | out_valid / out_ready| updated, link_lost, setpoints, history
//   cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle while out_ready does not stall; each request passes
// through the products register, then the setpoint update registers, then
// yaw integration into the result register.
// A stalled out_ready freezes all three stages together, so in_ready follows
// it. cfg_ready is always high. Reset (rst_n low, synchronous) clears the
// pipeline and all held setpoints and restores the register defaults.
// ----------------------------------------------------------------------------
module rc_setpoint_shaper_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_new_frame,
  input  logic                                 in_hold_timeout,
  input  logic signed [rcss_pkg::CH_W-1:0]     in_throttle_channel,
  input  logic signed [rcss_pkg::CH_W-1:0]     in_roll_channel,
  input  logic signed [rcss_pkg::CH_W-1:0]     in_pitch_channel,
  input  logic signed [rcss_pkg::CH_W-1:0]     in_yaw_channel,
  input  logic signed [rcss_pkg::CH_W-1:0]     in_kill_channel,
  input  logic signed [rcss_pkg::CH_W-1:0]     in_aux_channel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_updated,
  output logic                                 out_link_lost,
  output logic signed [rcss_pkg::REF_W-1:0]    out_roll_ref,
  output logic signed [rcss_pkg::REF_W-1:0]    out_pitch_ref,
  output logic signed [rcss_pkg::YAW_W-1:0]    out_yaw_ref,
  output logic signed [rcss_pkg::REF_W-1:0]    out_yaw_rate_now,
  output logic signed [rcss_pkg::REF_W-1:0]    out_yaw_rate_last,
  output logic signed [rcss_pkg::REF_W-1:0]    out_throttle_ref,
  output logic signed [rcss_pkg::CH_W-1:0]     out_kill_now,
  output logic signed [rcss_pkg::CH_W-1:0]     out_kill_last,
  output logic signed [rcss_pkg::CH_W-1:0]     out_aux_now,
  output logic signed [rcss_pkg::CH_W-1:0]     out_aux_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rcss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data
);
  import rcss_pkg::*;

  // configuration
  logic [1:0]          flight_mode_r;
  logic                debug_mode_r;
  logic [GAIN_W-1:0]   roll_gain_stab_r, pitch_gain_stab_r;
  logic [GAIN_W-1:0]   roll_gain_acro_r, pitch_gain_acro_r, yaw_rate_gain_r;
  logic [2*GAIN_W-1:0] throttle_limits_r;

  // held setpoint state
  logic signed [REF_W-1:0] roll_hold_r, pitch_hold_r, throttle_hold_r;
  logic signed [REF_W-1:0] rate_cur_r, rate_prev_r;
  logic signed [YAW_W-1:0] yaw_accum_r;
  logic signed [CH_W-1:0]  kill_now_r, kill_last_r, aux_now_r, aux_last_r;
  logic [COUNT_W-1:0]      silence_cnt_r;
  logic                    lost_r;

  // integration stage
  logic                        s3_valid_r, s3_upd_r;
  logic signed [YAW_INC_W-1:0] s3_inc_r, s3_inc_nxt;

  logic out_valid_r;
  logic advance;
  s1_t  s1;

  logic signed [REF_W-1:0]     roll_new, pitch_new, thr_new, rate_scaled, rate_new;
  logic signed [YAW_SUM_W-1:0] rate_sum;
  logic [YAW_SUM_W-1:0]        rate_mag;
  logic [YAW_X_W-1:0]          yaw_x;
  logic [YAW_MUL_W-1:0]        yaw_mul;
  logic [YAW_Q_W-1:0]          yaw_q;
  logic signed [YAW_W:0]       yaw_sum;
  logic signed [YAW_W-1:0]     yaw_sat;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  rcss_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .advance             (advance),
    .in_valid            (in_valid),
    .in_new_frame        (in_new_frame),
    .in_hold_timeout     (in_hold_timeout),
    .in_throttle_channel (in_throttle_channel),
    .in_roll_channel     (in_roll_channel),
    .in_pitch_channel    (in_pitch_channel),
    .in_yaw_channel      (in_yaw_channel),
    .in_kill_channel     (in_kill_channel),
    .in_aux_channel      (in_aux_channel),
    .flight_mode         (flight_mode_r),
    .roll_gain_stab      (roll_gain_stab_r),
    .pitch_gain_stab     (pitch_gain_stab_r),
    .roll_gain_acro      (roll_gain_acro_r),
    .pitch_gain_acro     (pitch_gain_acro_r),
    .yaw_rate_gain       (yaw_rate_gain_r),
    .throttle_limits     (throttle_limits_r),
    .s1                  (s1)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_mode_r     <= MODE_STAB;
      debug_mode_r      <= 1'b0;
      roll_gain_stab_r  <= GAIN_W'(4096);
      pitch_gain_stab_r <= GAIN_W'(4096);
      roll_gain_acro_r  <= GAIN_W'(8192);
      pitch_gain_acro_r <= GAIN_W'(8192);
      yaw_rate_gain_r   <= GAIN_W'(8192);
      throttle_limits_r <= 32'h4000_1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FLIGHT_MODE:     flight_mode_r     <= cfg_data[1:0];
        CFG_DEBUG_MODE:      debug_mode_r      <= cfg_data[0];
        CFG_ROLL_GAIN_STAB:  roll_gain_stab_r  <= cfg_data[GAIN_W-1:0];
        CFG_PITCH_GAIN_STAB: pitch_gain_stab_r <= cfg_data[GAIN_W-1:0];
        CFG_ROLL_GAIN_ACRO:  roll_gain_acro_r  <= cfg_data[GAIN_W-1:0];
        CFG_PITCH_GAIN_ACRO: pitch_gain_acro_r <= cfg_data[GAIN_W-1:0];
        CFG_YAW_RATE_GAIN:   yaw_rate_gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_THROTTLE_LIMITS: throttle_limits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Setpoint update: round, saturate, deadzone, trapezoid step
  always_comb begin
    roll_new    = round_sat17(s1.roll_prod, '0);
    pitch_new   = round_sat17(s1.pitch_prod, '0);
    thr_new     = round_sat17(s1.thr_prod, {2'b00, throttle_limits_r[GAIN_W-1:0]});
    rate_scaled = round_sat17(s1.yaw_prod, '0);
    rate_new    = (rate_scaled > DEADZONE_NEG && rate_scaled < DEADZONE_POS) ?
                  '0 : rate_scaled;

    rate_sum = YAW_SUM_W'(rate_new) + YAW_SUM_W'(rate_cur_r);
    rate_mag = rate_sum[YAW_SUM_W-1] ? YAW_SUM_W'(-rate_sum) : YAW_SUM_W'(rate_sum);
    yaw_x    = YAW_X_W'(rate_mag) + YAW_X_W'(TICK_RATE_HZ);
    yaw_mul  = YAW_MUL_W'(yaw_x) * YAW_MUL_W'(YAW_RECIP64[YAW_RECIP_W-1:0]);
    yaw_q    = yaw_mul[YAW_MUL_W-1:YAW_SHIFT];
    s3_inc_nxt = rate_sum[YAW_SUM_W-1] ? -YAW_INC_W'(yaw_q) : YAW_INC_W'(yaw_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_hold_r     <= '0;
      pitch_hold_r    <= '0;
      throttle_hold_r <= '0;
      rate_cur_r      <= '0;
      rate_prev_r     <= '0;
      kill_now_r      <= '0;
      kill_last_r     <= '0;
      aux_now_r       <= '0;
      aux_last_r      <= '0;
      silence_cnt_r   <= '0;
      lost_r          <= 1'b0;
      s3_valid_r      <= 1'b0;
      s3_upd_r        <= 1'b0;
      s3_inc_r        <= '0;
    end else if (advance) begin
      s3_valid_r <= s1.valid;
      s3_upd_r   <= 1'b0;
      s3_inc_r   <= '0;
      if (s1.valid && !lost_r) begin
        if (!s1.frame) begin
          // silent tick: advance the timeout unless held or in debug mode
          if (!debug_mode_r && !s1.hold) begin
            if (silence_cnt_r >= TIMEOUT_TICKS) begin
              lost_r <= 1'b1;
            end else if (silence_cnt_r != COUNT_MAX) begin
              silence_cnt_r <= silence_cnt_r + COUNT_W'(1);
            end
          end
        end else begin
          silence_cnt_r <= '0;
          if (s1.angle_en) begin
            roll_hold_r  <= roll_new;
            pitch_hold_r <= pitch_new;
          end
          rate_prev_r     <= rate_cur_r;
          rate_cur_r      <= rate_new;
          throttle_hold_r <= thr_new;
          kill_last_r     <= kill_now_r;
          kill_now_r      <= s1.kill;
          aux_last_r      <= aux_now_r;
          aux_now_r       <= s1.aux;
          s3_upd_r        <= 1'b1;
          s3_inc_r        <= s3_inc_nxt;
        end
      end
    end
  end

  // Yaw integration and result register
  always_comb begin
    yaw_sum = {yaw_accum_r[YAW_W-1], yaw_accum_r} + (YAW_W+1)'(s3_inc_r);
    if (yaw_sum[YAW_W] != yaw_sum[YAW_W-1]) begin
      yaw_sat = yaw_sum[YAW_W] ? {1'b1, {(YAW_W-1){1'b0}}} : {1'b0, {(YAW_W-1){1'b1}}};
    end else begin
      yaw_sat = yaw_sum[YAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      yaw_accum_r <= '0;
    end else if (advance) begin
      out_valid_r <= s3_valid_r;
      if (s3_valid_r) begin
        yaw_accum_r <= yaw_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_valid_r) begin
      out_updated       <= s3_upd_r;
      out_link_lost     <= lost_r;
      out_roll_ref      <= roll_hold_r;
      out_pitch_ref     <= pitch_hold_r;
      out_yaw_ref       <= yaw_sat;
      out_yaw_rate_now  <= rate_cur_r;
      out_yaw_rate_last <= rate_prev_r;
      out_throttle_ref  <= throttle_hold_r;
      out_kill_now      <= kill_now_r;
      out_kill_last     <= kill_last_r;
      out_aux_now       <= aux_now_r;
      out_aux_last      <= aux_last_r;
    end
  end

  // Link loss never clears once latched
  a_lost_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    lost_r |=> lost_r)
    else $error("link loss flag dropped");

  // A lost link never reports fresh setpoints
  a_lost_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_link_lost) |-> !out_updated)
    else $error("update reported with link lost");

  // Silence counter stops at the timeout limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    silence_cnt_r <= TIMEOUT_TICKS)
    else $error("silence counter past timeout");

  // Held yaw rate is zero or outside the deadzone
  a_deadzone: assert property (@(posedge clk) disable iff (!rst_n)
    (rate_cur_r == '0) || (rate_cur_r >= DEADZONE_POS) || (rate_cur_r <= DEADZONE_NEG))
    else $error("yaw rate inside deadzone");

endmodule

// File: rtl/rcss_front.sv
// ----------------------------------------------------------------------------
// rcss_front
// Input register stage: forms the four stick-by-gain products of a request.
// ----------------------------------------------------------------------------
module rcss_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  logic                                in_valid,
  input  logic                                in_new_frame,
  input  logic                                in_hold_timeout,
  input  logic signed [rcss_pkg::CH_W-1:0]    in_throttle_channel,
  input  logic signed [rcss_pkg::CH_W-1:0]    in_roll_channel,
  input  logic signed [rcss_pkg::CH_W-1:0]    in_pitch_channel,
  input  logic signed [rcss_pkg::CH_W-1:0]    in_yaw_channel,
  input  logic signed [rcss_pkg::CH_W-1:0]    in_kill_channel,
  input  logic signed [rcss_pkg::CH_W-1:0]    in_aux_channel,
  input  logic [1:0]                          flight_mode,
  input  logic [rcss_pkg::GAIN_W-1:0]         roll_gain_stab,
  input  logic [rcss_pkg::GAIN_W-1:0]         pitch_gain_stab,
  input  logic [rcss_pkg::GAIN_W-1:0]         roll_gain_acro,
  input  logic [rcss_pkg::GAIN_W-1:0]         pitch_gain_acro,
  input  logic [rcss_pkg::GAIN_W-1:0]         yaw_rate_gain,
  input  logic [2*rcss_pkg::GAIN_W-1:0]       throttle_limits,
  output rcss_pkg::s1_t                       s1
);
  import rcss_pkg::*;

  logic signed [REF_W-1:0] roll_op, pitch_op, yaw_op, thr_op;
  logic signed [REF_W-1:0] roll_g, pitch_g, yaw_g, thr_span;
  s1_t s1_r, s1_nxt;

  always_comb begin
    roll_op  = REF_W'(in_roll_channel);
    pitch_op = -REF_W'(in_pitch_channel);
    yaw_op   = REF_W'(in_yaw_channel);
    thr_op   = REF_W'(in_throttle_channel);

    roll_g   = (flight_mode == MODE_ACRO) ? {1'b0, roll_gain_acro}  : {1'b0, roll_gain_stab};
    pitch_g  = (flight_mode == MODE_ACRO) ? {1'b0, pitch_gain_acro} : {1'b0, pitch_gain_stab};
    yaw_g    = {1'b0, yaw_rate_gain};
    thr_span = {1'b0, throttle_limits[2*GAIN_W-1:GAIN_W]}
             - {1'b0, throttle_limits[GAIN_W-1:0]};

    s1_nxt.valid      = in_valid;
    s1_nxt.frame      = in_new_frame;
    s1_nxt.hold       = in_hold_timeout;
    s1_nxt.angle_en   = (flight_mode == MODE_STAB) || (flight_mode == MODE_ACRO);
    s1_nxt.roll_prod  = roll_op * roll_g;
    s1_nxt.pitch_prod = pitch_op * pitch_g;
    s1_nxt.yaw_prod   = yaw_op * yaw_g;
    s1_nxt.thr_prod   = thr_op * thr_span;
    s1_nxt.kill       = in_kill_channel;
    s1_nxt.aux        = in_aux_channel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (advance) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule
